@@ design/spda_pkg.sv @@
// ----------------------------------------------------------------------------
// spda_pkg
// Shared constants for the predicted-density accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package spda_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned VAL_W     = 32;

  localparam logic [16:0] ONE_FX  = 17'(1 << FRAC_BITS);
  localparam logic [16:0] HALF_FX = 17'(1 << (FRAC_BITS - 1));

  localparam logic [31:0] ERR_THRESHOLD = 32'((64'd1 << FRAC_BITS) / 64'd1000000);

  localparam logic [47:0] RATE_POS_MAX = {1'b0, {47{1'b1}}};
  localparam logic [47:0] RATE_NEG_MAG = {1'b1, {47{1'b0}}};

  localparam logic [7:0] CFG_INV_H     = 8'd0;
  localparam logic [7:0] CFG_GRAD_COEF = 8'd1;
  localparam logic [7:0] CFG_TIME_STEP = 8'd2;
  localparam logic [7:0] CFG_REST_DENS = 8'd3;

endpackage

`default_nettype wire

@@ design/spda_mul.sv @@
// ----------------------------------------------------------------------------
// spda_mul
// Shared 32x32 unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module spda_mul import spda_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic [VAL_W-1:0]  a_i,
  input  wire logic [VAL_W-1:0]  b_i,
  output logic [2*VAL_W-1:0]     prod_o
);

  logic [2*VAL_W-1:0] prod_q;

  // hold the product until the next issue
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q <= '0;
    end else if (en_i) begin
      prod_q <= {{VAL_W{1'b0}}, a_i} * {{VAL_W{1'b0}}, b_i};
    end
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

@@ design/spda_sqrt.sv @@
// ----------------------------------------------------------------------------
// spda_sqrt
// Digit-by-digit integer square root, one result bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spda_sqrt import spda_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] radicand_i,
  output logic             done_o,
  output logic [31:0]      root_o
);

  logic [63:0] rad_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;
  logic [4:0]  cnt_q;
  logic        busy_q;
  logic        done_q;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;
  logic [35:0] rem_sub;

  assign rem_sh  = {rem_q, rad_q[63:62]};
  assign trial   = {2'b00, root_q, 2'b01};
  assign ge      = rem_sh >= trial;
  assign rem_sub = rem_sh - trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rad_q  <= '0;
      rem_q  <= '0;
      root_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        rad_q  <= radicand_i;
        rem_q  <= '0;
        root_q <= '0;
      end else if (busy_q) begin
        rad_q  <= {rad_q[61:0], 2'b00};
        rem_q  <= ge ? rem_sub[33:0] : rem_sh[33:0];
        root_q <= {root_q[30:0], ge};
        cnt_q  <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

@@ design/spda_div.sv @@
// ----------------------------------------------------------------------------
// spda_div
// Restoring 64 by 32 bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spda_div import spda_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [63:0] dividend_i,
  input  wire logic [31:0] divisor_i,
  output logic             done_o,
  output logic [63:0]      quot_o
);

  logic [63:0] n_q;
  logic [31:0] d_q;
  logic [31:0] rem_q;
  logic [5:0]  cnt_q;
  logic        busy_q;
  logic        done_q;

  logic [32:0] r_sh;
  logic        ge;
  logic [32:0] r_sub;

  assign r_sh  = {rem_q, n_q[63]};
  assign ge    = r_sh >= {1'b0, d_q};
  assign r_sub = r_sh - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      n_q    <= '0;
      d_q    <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        n_q    <= dividend_i;
        d_q    <= divisor_i;
        rem_q  <= '0;
      end else if (busy_q) begin
        // shift the quotient bit in where the dividend bit left
        n_q   <= {n_q[62:0], ge};
        rem_q <= ge ? r_sub[31:0] : r_sh[31:0];
        cnt_q <= cnt_q + 6'd1;
        if (cnt_q == 6'd63) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = n_q;

endmodule

`default_nettype wire

@@ design/sph_predicted_density_accumulate.sv @@
// ----------------------------------------------------------------------------
// sph_predicted_density_accumulate
// Per-pair cubic-spline density-rate accumulation and density prediction.
// ----------------------------------------------------------------------------
// One particle-neighbour pair is taken at a time; the block is not ready again
// until the pair is finished. A kept pair runs the 32-step square root and then
// the 64-step divider for the velocity ratio; a skipped pair leaves out the
// divider. The last pair of a particle also produces the predicted density.
// A result sits in an output register, so work goes on while it waits, until
// the next result is due.
// All products go through one shared 32x32 multiplier.
`default_nettype none

module sph_predicted_density_accumulate import spda_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // tdata: dx, dy, dz, dvx, dvy, dvz, own_density (32 bits each)
  input  wire logic [223:0] s_axis_tdata_i,
  // tuser: first_pair, pass_start
  input  wire logic [1:0]   s_axis_tuser_i,
  input  wire logic         s_axis_tlast_i,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // tdata: predicted_density (32), density_error_sum (48)
  output logic [79:0]       m_axis_tdata_o,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [7:0]   cfg_index_i,
  input  wire logic [31:0]  cfg_data_i
);

  typedef enum logic [3:0] {
    S_IDLE, S_PROD, S_SQRT, S_QMUL, S_QCHK, S_WMUL, S_AMUL, S_DIVW,
    S_RLO, S_RHI, S_TERM, S_ACC, S_DLO, S_DHI, S_PRED, S_EMIT
  } state_e;

  state_e state_q;

  logic [31:0] inv_h_q;
  logic [31:0] gcoef_q;
  logic [15:0] tstep_q;
  logic [31:0] rest_q;

  logic [31:0] dr_q [3];
  logic [31:0] dv_q [3];
  logic [31:0] own_q;
  logic        last_q;

  logic [47:0] rate_q;
  logic [47:0] err_total_q;

  logic [2:0]  cnt_q;
  logic        sign_q;
  logic signed [49:0] dot_q;
  logic [63:0] d2_q;
  logic [31:0] dist_q;
  logic [16:0] q_q;
  logic        neg_q;
  logic [31:0] a_q;
  logic [63:0] ratio_q;
  logic [63:0] plo_q;
  logic [63:0] term_q;
  logic [47:0] dm_q;

  logic        out_valid_q;
  logic [31:0] out_pred_q;
  logic [47:0] out_err_q;

  // ---------------- magnitudes ----------------
  logic [31:0] dr_mag [3];
  logic [31:0] dv_mag [3];
  logic        dr_neg [3];
  logic        dv_neg [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dr_neg[i] = dr_q[i][31];
      dv_neg[i] = dv_q[i][31];
      dr_mag[i] = dr_q[i][31] ? (~dr_q[i] + 32'd1) : dr_q[i];
      dv_mag[i] = dv_q[i][31] ? (~dv_q[i] + 32'd1) : dv_q[i];
    end
  end

  logic [31:0] gc_mag;
  logic [49:0] dot_mag;
  logic [47:0] rate_mag;

  assign gc_mag   = gcoef_q[31] ? (~gcoef_q + 32'd1) : gcoef_q;
  assign dot_mag  = dot_q[49] ? 50'(-dot_q) : 50'(dot_q);
  assign rate_mag = rate_q[47] ? (~rate_q + 48'd1) : rate_q;

  // ---------------- shared units ----------------
  logic        mul_en;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] prod;

  logic        sqrt_start;
  logic [63:0] sqrt_rad;
  logic        sqrt_done;
  logic [31:0] sqrt_root;

  logic        div_start;
  logic        div_done;
  logic [63:0] div_quot;

  spda_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (mul_en),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  spda_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sqrt_start),
    .radicand_i (sqrt_rad),
    .done_o     (sqrt_done),
    .root_o     (sqrt_root)
  );

  spda_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({dot_mag[47:0], 16'd0}),
    .divisor_i  (dist_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // ---------------- product accumulation ----------------
  logic signed [63:0] prod_signed;
  logic signed [63:0] prod_floor;
  logic signed [49:0] dot_next;
  logic [63:0]        d2_next;

  assign prod_signed = sign_q ? -$signed(prod) : $signed(prod);
  assign prod_floor  = prod_signed >>> FRAC_BITS;
  assign dot_next    = (cnt_q != 3'd0 && cnt_q <= 3'd3) ? dot_q + prod_floor[49:0] : dot_q;
  assign d2_next     = (cnt_q >= 3'd4) ? d2_q + prod : d2_q;

  assign sqrt_start = (state_q == S_PROD) && (cnt_q == 3'd6);
  assign sqrt_rad   = d2_next;

  // ---------------- q and kernel ----------------
  logic [47:0] q_full;
  logic        skip;
  logic [16:0] one_minus_q;
  logic [18:0] w_second;

  assign q_full      = prod[63:16];
  assign skip        = (q_full == 48'd0) || (q_full > {31'd0, ONE_FX});
  assign one_minus_q = ONE_FX - q_q;
  assign w_second    = {ONE_FX, 1'b0} + 19'd0 - 19'(3 * q_q);

  assign div_start = (state_q == S_QCHK) && !skip;

  // ---------------- term ----------------
  logic [95:0] full96;
  logic [47:0] lim;
  logic signed [48:0] acc49;

  assign full96 = {prod, 32'd0} + {32'd0, plo_q};

  always_comb begin
    if (neg_q) begin
      lim   = (term_q >= {16'd0, RATE_NEG_MAG}) ? RATE_NEG_MAG : term_q[47:0];
      acc49 = $signed({rate_q[47], rate_q}) - $signed({1'b0, lim});
    end else begin
      lim   = (term_q > {16'd0, RATE_POS_MAX}) ? RATE_POS_MAX : term_q[47:0];
      acc49 = $signed({rate_q[47], rate_q}) + $signed({1'b0, lim});
    end
  end

  // ---------------- prediction ----------------
  logic [79:0]        dm_full;
  logic signed [49:0] pred_raw;
  logic signed [49:0] pred_lo;
  logic [31:0]        pred;
  logic [31:0]        err;
  logic [48:0]        err_sum;
  logic [47:0]        err_next;
  logic               emit;

  assign dm_full = {prod[47:0], 32'd0} + {16'd0, plo_q};
  assign emit    = (state_q == S_EMIT) && (!out_valid_q || m_axis_tready_i);

  always_comb begin
    pred_raw = rate_q[47] ? $signed({18'd0, own_q}) - $signed({2'b00, dm_q})
                          : $signed({18'd0, own_q}) + $signed({2'b00, dm_q});
    pred_lo  = (pred_raw < $signed({18'd0, rest_q})) ? $signed({18'd0, rest_q}) : pred_raw;
    pred     = (pred_lo > $signed({18'd0, 32'hFFFF_FFFF})) ? 32'hFFFF_FFFF : pred_lo[31:0];
    err      = (pred > rest_q) ? pred - rest_q : 32'd0;
    err_sum  = {1'b0, err_total_q} + {17'd0, err};
    if (err > ERR_THRESHOLD) begin
      err_next = err_sum[48] ? {48{1'b1}} : err_sum[47:0];
    end else begin
      err_next = err_total_q;
    end
  end

  // ---------------- multiplier operands ----------------
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    unique case (state_q)
      S_PROD: begin
        if (cnt_q < 3'd3) begin
          mul_en = 1'b1;
          mul_a  = dr_mag[cnt_q[1:0]];
          mul_b  = dv_mag[cnt_q[1:0]];
        end else if (cnt_q < 3'd6) begin
          mul_en = 1'b1;
          mul_a  = dr_mag[2'(cnt_q - 3'd3)];
          mul_b  = dr_mag[2'(cnt_q - 3'd3)];
        end
      end
      S_QMUL: begin
        mul_en = 1'b1;
        mul_a  = dist_q;
        mul_b  = inv_h_q;
      end
      S_WMUL: begin
        mul_en = 1'b1;
        if (q_q <= HALF_FX) begin
          mul_a = {15'd0, q_q};
          mul_b = {13'd0, w_second};
        end else begin
          mul_a = {15'd0, one_minus_q};
          mul_b = {15'd0, one_minus_q};
        end
      end
      S_AMUL: begin
        mul_en = 1'b1;
        mul_a  = gc_mag;
        mul_b  = prod[47:16];
      end
      S_RLO: begin
        mul_en = 1'b1;
        mul_a  = a_q;
        mul_b  = ratio_q[31:0];
      end
      S_RHI: begin
        mul_en = 1'b1;
        mul_a  = a_q;
        mul_b  = ratio_q[63:32];
      end
      S_DLO: begin
        mul_en = 1'b1;
        mul_a  = rate_mag[31:0];
        mul_b  = {16'd0, tstep_q};
      end
      S_DHI: begin
        mul_en = 1'b1;
        mul_a  = {16'd0, rate_mag[47:32]};
        mul_b  = {16'd0, tstep_q};
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  // ---------------- sequencer ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      inv_h_q     <= 32'd65536;
      gcoef_q     <= 32'd0;
      tstep_q     <= 16'd328;
      rest_q      <= 32'd65536000;
      rate_q      <= '0;
      err_total_q <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_INV_H:     inv_h_q <= cfg_data_i;
          CFG_GRAD_COEF: gcoef_q <= cfg_data_i;
          CFG_TIME_STEP: tstep_q <= cfg_data_i[15:0];
          CFG_REST_DENS: rest_q  <= cfg_data_i;
          default: ;
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid_i) begin
            for (int i = 0; i < 3; i++) begin
              dr_q[i] <= s_axis_tdata_i[32*i +: 32];
              dv_q[i] <= s_axis_tdata_i[96 + 32*i +: 32];
            end
            own_q  <= s_axis_tdata_i[223:192];
            last_q <= s_axis_tlast_i;
            if (s_axis_tuser_i[1]) err_total_q <= '0;
            if (s_axis_tuser_i[0]) rate_q <= '0;
            dot_q   <= '0;
            d2_q    <= '0;
            cnt_q   <= '0;
            state_q <= S_PROD;
          end
        end
        S_PROD: begin
          dot_q  <= dot_next;
          d2_q   <= d2_next;
          if (cnt_q < 3'd3) begin
            sign_q <= dr_neg[cnt_q[1:0]] ^ dv_neg[cnt_q[1:0]];
          end
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd6) begin
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sqrt_done) begin
            dist_q  <= sqrt_root;
            state_q <= S_QMUL;
          end
        end
        S_QMUL: begin
          state_q <= S_QCHK;
        end
        S_QCHK: begin
          q_q   <= q_full[16:0];
          neg_q <= (gcoef_q[31] == dot_q[49]);
          if (skip) begin
            state_q <= last_q ? S_DLO : S_IDLE;
          end else begin
            state_q <= S_WMUL;
          end
        end
        S_WMUL: begin
          state_q <= S_AMUL;
        end
        S_AMUL: begin
          state_q <= S_DIVW;
        end
        S_DIVW: begin
          a_q <= prod[47:16];
          if (div_done) begin
            ratio_q <= div_quot;
            state_q <= S_RLO;
          end
        end
        S_RLO: begin
          state_q <= S_RHI;
        end
        S_RHI: begin
          plo_q   <= prod;
          state_q <= S_TERM;
        end
        S_TERM: begin
          term_q  <= (full96[95:64] != 32'd0) ? {64{1'b1}} : full96[79:16];
          state_q <= S_ACC;
        end
        S_ACC: begin
          if (acc49[48] != acc49[47]) begin
            rate_q <= acc49[48] ? RATE_NEG_MAG : RATE_POS_MAX;
          end else begin
            rate_q <= acc49[47:0];
          end
          state_q <= last_q ? S_DLO : S_IDLE;
        end
        S_DLO: begin
          state_q <= S_DHI;
        end
        S_DHI: begin
          plo_q   <= prod;
          state_q <= S_PRED;
        end
        S_PRED: begin
          dm_q    <= dm_full[63:16];
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          // hold until the output register is free
          if (emit) begin
            out_pred_q  <= pred;
            out_err_q   <= err_next;
            err_total_q <= err_next;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign cfg_ready_o     = 1'b1;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {out_err_q, out_pred_q};

  // ---------------- assertions ----------------
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("block ready right after accepting an item");

  a_err_tracks_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) && (!out_valid_q || m_axis_tready_i)
      |=> m_axis_tvalid_o && (m_axis_tdata_o[79:32] == err_total_q))
    else $error("emitted error sum differs from running total");

  a_pred_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> out_pred_q >= rest_q)
    else $error("predicted density below rest density");

endmodule

`default_nettype wire

@@ tb/sph_predicted_density_accumulate_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sph_predicted_density_accumulate_test
// Drives particle-neighbour pairs and register writes into the density
// accumulator and checks each predicted density and error sum against a
// cycle-free predictor kept alongside the stimulus.
// ----------------------------------------------------------------------------
`default_nettype none

module sph_predicted_density_accumulate_test;
  import spda_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1200000;

  typedef struct {
    logic [31:0] dx, dy, dz, dvx, dvy, dvz, own;
    logic        first, last, pstart;
  } pair_t;

  typedef struct {
    logic [31:0] dens;
    logic [47:0] err;
  } density_t;

  typedef struct {
    pair_t    p;
    logic     chk;
    density_t res;
  } row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic [223:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic s_tlast = 1'b0, s_tvalid = 1'b0;
  wire s_tready;
  wire [79:0] m_tdata;
  wire m_tvalid;
  logic m_tready = 1'b0;
  logic cfg_valid = 1'b0;
  wire cfg_ready;
  logic [7:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  sph_predicted_density_accumulate dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tdata_i(s_tdata), .s_axis_tuser_i(s_tuser),
    .s_axis_tlast_i(s_tlast), .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .m_axis_tdata_o(m_tdata), .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [31:0] inv_h = 32'd65536;
  logic signed [31:0] coef = '0;
  logic [15:0] dt = 16'd328;
  logic [31:0] rho0 = 32'd65536000;
  logic signed [47:0] rate_acc = '0;
  logic [47:0] err_acc = '0;

  density_t density_q[$];
  int errors = 0, results = 0, pairs = 0;
  int send_idle = 0, recv_stall = 0, hold_off = 0;
  longint cycles = 0;

  function automatic logic [63:0] isqrt(logic [65:0] v);
    logic [65:0] r, b;
    r = 0;
    b = 66'd1 << 64;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r[63:0];
  endfunction

  function automatic logic [63:0] absval(logic signed [63:0] v);
    return v < 0 ? -v : v;
  endfunction

  // advance the predictor by one pair; returns 1 when a result is due
  function automatic bit predict_density(pair_t p, output density_t r);
    logic signed [63:0] d[3], v[3], dot, s, pmax, nmax, pred;
    logic [65:0] d2;
    logic [63:0] rdist, q, wmag, ratio, a, dm, pp, e;
    logic [127:0] term;
    bit neg;
    pmax = (64'sd1 <<< 47) - 1;
    nmax = -(64'sd1 <<< 47);
    if (p.pstart) err_acc = '0;
    if (p.first) rate_acc = '0;
    d[0] = $signed(p.dx); d[1] = $signed(p.dy); d[2] = $signed(p.dz);
    v[0] = $signed(p.dvx); v[1] = $signed(p.dvy); v[2] = $signed(p.dvz);
    d2 = 0;
    dot = 0;
    for (int i = 0; i < 3; i++) begin
      d2 += absval(d[i]) * absval(d[i]);
      dot += (d[i] * v[i]) >>> FRAC_BITS;
    end
    rdist = isqrt(d2);
    q = (rdist * inv_h) >> FRAC_BITS;
    if (q != 0 && q <= 64'(ONE_FX) && rdist != 0) begin
      if (q <= 64'(HALF_FX)) wmag = (q * (2 * 64'(ONE_FX) - 3 * q)) >> FRAC_BITS;
      else wmag = ((64'(ONE_FX) - q) * (64'(ONE_FX) - q)) >> FRAC_BITS;
      ratio = (absval(dot) << FRAC_BITS) / rdist;
      a = (absval(64'(coef)) * wmag) >> FRAC_BITS;
      term = 128'(a) * 128'(ratio);
      // hold all ones when the full product leaves 64 bits
      if (term[127:64] != 0) term = {64'd0, 64'hFFFF_FFFF_FFFF_FFFF};
      else term = term >> FRAC_BITS;
      neg = !((coef < 0) != (dot < 0));
      if (neg) s = (term >= 128'(64'd1 << 47)) ? nmax : -$signed(term[63:0]);
      else s = (term > 128'(pmax)) ? pmax : $signed(term[63:0]);
      s = 64'(rate_acc) + s;
      if (s > pmax) s = pmax;
      if (s < nmax) s = nmax;
      rate_acc = s[47:0];
    end
    if (!p.last) return 0;
    dm = (absval(64'(rate_acc)) * dt) >> FRAC_BITS;
    pred = $signed({32'd0, p.own});
    pred = rate_acc < 0 ? pred - $signed(dm) : pred + $signed(dm);
    if (pred < $signed({32'd0, rho0})) pred = {32'd0, rho0};
    pp = pred;
    if (pp > 64'hFFFF_FFFF) pp = 64'hFFFF_FFFF;
    e = pp > rho0 ? pp - rho0 : 0;
    if (e > 64'(ERR_THRESHOLD)) begin
      e = 64'(err_acc) + e;
      err_acc = e > 64'hFFFF_FFFF_FFFF ? 48'hFFFF_FFFF_FFFF : e[47:0];
    end
    r.dens = pp[31:0];
    r.err = err_acc;
    return 1;
  endfunction

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // result checking
  always @(posedge clk_i) begin
    if (rst_ni && m_tvalid && m_tready) begin
      results <= results + 1;
      if (density_q.size() == 0) begin
        $error("result with nothing expected: %h", m_tdata);
        errors++;
      end else begin
        density_t x;
        x = density_q.pop_front();
        if (m_tdata[31:0] !== x.dens) begin
          $error("predicted_density exp %h got %h", x.dens, m_tdata[31:0]);
          errors++;
        end
        if (m_tdata[79:32] !== x.err) begin
          $error("density_error_sum exp %h got %h", x.err, m_tdata[79:32]);
          errors++;
        end
      end
    end
  end

  // receiver: random stalls, plus a long hold-off counted here
  always @(posedge clk_i) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  task automatic write_reg(logic [7:0] idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_INV_H:     inv_h = val;
      CFG_GRAD_COEF: coef = val;
      CFG_TIME_STEP: dt = val[15:0];
      CFG_REST_DENS: rho0 = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // valid stays up after an accept; the next call either offers a new item or idles
  task automatic send_pair(pair_t p, bit chk, density_t want);
    density_t r;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tdata <= {p.own, p.dvz, p.dvy, p.dvx, p.dz, p.dy, p.dx};
    s_tuser <= {p.pstart, p.first};
    s_tlast <= p.last;
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_tready);
    pairs++;
    if (predict_density(p, r)) begin
      if (chk && (r.dens !== want.dens || r.err !== want.err)) begin
        $error("table row disagrees with predictor: %h %h", want.dens, want.err);
        errors++;
      end
      density_q.insert(density_q.size(), r);
    end
  endtask

  task automatic drain;
    s_tvalid <= 1'b0;
    while (density_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_coord(int scale);
    logic [31:0] v;
    v = $urandom_range(scale);
    return $urandom_range(1) ? -v : v;
  endfunction

  function automatic pair_t rnd_pair(bit first, bit last, int scale);
    pair_t p;
    p.dx = rnd_coord(scale); p.dy = rnd_coord(scale); p.dz = rnd_coord(scale);
    p.dvx = $urandom(); p.dvy = $urandom(); p.dvz = $urandom();
    if ($urandom_range(3) == 0) begin
      p.dvx = rnd_coord(65536 * 4); p.dvy = rnd_coord(65536 * 4);
      p.dvz = rnd_coord(65536 * 4);
    end
    p.own = $urandom_range(3) == 0 ? $urandom() : 32'd65536000 + $urandom_range(1 << 22);
    p.first = first; p.last = last; p.pstart = $urandom_range(19) == 0;
    return p;
  endfunction

  row_t table_rows[$];
  density_t nothing;

  task automatic add_row(logic [31:0] dx, dy, dz, dvx, dvy, dvz, own,
                         bit f, bit l, bit ps, bit chk, logic [31:0] dens, logic [47:0] err);
    row_t r;
    r.p.dx = dx; r.p.dy = dy; r.p.dz = dz;
    r.p.dvx = dvx; r.p.dvy = dvy; r.p.dvz = dvz; r.p.own = own;
    r.p.first = f; r.p.last = l; r.p.pstart = ps;
    r.chk = chk; r.res.dens = dens; r.res.err = err;
    table_rows.insert(table_rows.size(), r);
  endtask

  initial begin
    pair_t p;
    nothing.dens = '0; nothing.err = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // after reset coef is 0: density is own floored at rest, error only above rest
    add_row(32'h8000, 0, 0, 32'h10000, 0, 0, 32'd0, 1, 1, 1, 1, 32'd65536000, 48'd0);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
            32'h7FFF_FFFF, 32'hFFFF_FFFF, 1, 1, 0, 1, 32'hFFFF_FFFF,
            48'(32'hFFFF_FFFF - 32'd65536000));
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'h8000_0000, 32'd0, 1, 1, 1, 1, 32'd65536000, 48'd0);
    for (int i = 0; i < table_rows.size(); i++)
      send_pair(table_rows[i].p, table_rows[i].chk, table_rows[i].res);
    drain();

    write_reg(CFG_GRAD_COEF, 32'h8000_0000);
    write_reg(CFG_TIME_STEP, 16'hFFFF);
    write_reg(CFG_REST_DENS, 32'd0);
    write_reg(CFG_INV_H, 32'h0002_0000);
    write_reg(8'd7, 32'hDEAD_BEEF);
    table_rows.delete();
    // kept pairs on both sides of q = 1/2, zero distance, q exactly one
    add_row(32'h2000, 0, 0, 32'h10000, 0, 0, 32'd1000, 1, 0, 1, 0, 0, 0);
    add_row(0, 32'h6000, 0, 0, 32'hFFFF_0000, 0, 32'd1000, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'd1000, 0, 0, 0, 0, 0, 0);
    add_row(0, 0, 32'h8000, 0, 0, 32'h7FFF_FFFF, 32'd5000, 0, 1, 0, 0, 0, 0);
    add_row(32'h4000, 32'h4000, 32'h4000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
            32'hFFFF_FFFF, 1, 1, 0, 0, 0, 0);
    add_row(32'h3000, 32'hFFFF_D000, 32'h1000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1,
            32'd0, 1, 1, 1, 0, 0, 0);
    for (int i = 0; i < table_rows.size(); i++)
      send_pair(table_rows[i].p, 0, nothing);
    drain();

    write_reg(CFG_GRAD_COEF, 32'h7FFF_FFFF);
    write_reg(CFG_INV_H, 32'hFFFF_FFFF);
    table_rows.delete();
    add_row(32'h1, 0, 0, 32'h8000_0000, 0, 0, 32'd100, 1, 1, 1, 0, 0, 0);
    add_row(32'h1, 32'h1, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 32'd100, 1, 1, 0, 0, 0, 0);
    for (int i = 0; i < table_rows.size(); i++)
      send_pair(table_rows[i].p, 0, nothing);
    drain();
    write_reg(CFG_INV_H, 32'd0);
    send_pair(rnd_pair(1, 1, 65536), 0, nothing);
    drain();

    // random phases: particles of a few pairs, settings changed between phases
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 67; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 67; end
        default: begin send_idle = 13; recv_stall = 13; end
      endcase
      write_reg(CFG_INV_H, ph == 7 ? 32'hFFFF_FFFF : 32'h1_0000 + $urandom_range(32'h4_0000));
      write_reg(CFG_GRAD_COEF, ph == 6 ? 32'h8000_0000 : $urandom());
      write_reg(CFG_TIME_STEP, ph == 5 ? 16'd0 : $urandom_range(16'hFFFF));
      write_reg(CFG_REST_DENS, ph == 4 ? 32'hFFFF_FFFF : 32'd65536000 - $urandom_range(1 << 20));
      if (ph == 2) hold_off = 3000;
      for (int n = 0; n < 52; n++) begin
        int len;
        len = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) begin
          p = rnd_pair(k == 0, k == len - 1, ph == 7 ? 4 : 65536);
          if ($urandom_range(15) == 0) begin
            p.first = $urandom_range(1); p.last = $urandom_range(1);
            p.dx = $urandom(); p.dy = $urandom(); p.dz = $urandom();
          end
          send_pair(p, 0, nothing);
        end
      end
      drain();
    end

    $display("Covered %0d pairs and %0d density results over 8 register settings,",
             pairs, results);
    $display("with sender gaps, receiver stalls and one long output hold-off.");
    if (errors == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

@@ files.f @@
design/spda_pkg.sv
design/spda_mul.sv
design/spda_sqrt.sv
design/spda_div.sv
design/sph_predicted_density_accumulate.sv
tb/sph_predicted_density_accumulate_test.sv
